// ===== sv/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, codes and bus types of the least-frequently-used cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

	// table geometry
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	// field widths on the ports
	localparam int FUNC_W  = 2;
	localparam int KEY_W   = 64;
	localparam int VALUE_W = 64;
	localparam int SLOT_W  = 4;
	localparam int CFG_W   = 5;

	localparam int S_TDATA_W = ((KEY_W + VALUE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VALUE_W + SLOT_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// access counts
	localparam int COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_GET    = 2'd0,
		FN_UPDATE = 2'd1,
		FN_INSERT = 2'd2,
		FN_DELETE = 2'd3
	} func_t;

	// registered read of one slot
	typedef struct packed {
		logic                  valid;
		logic [COUNT_BITS-1:0] count;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} st_rd_t;

	// write of one slot
	typedef struct packed {
		logic                  we;
		logic                  key_en;
		logic                  val_en;
		logic [IDX_W-1:0]      idx;
		logic                  valid;
		logic [COUNT_BITS-1:0] count;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} st_wr_t;

endpackage
`default_nettype wire

// ===== sv/lfu_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_store
// Slot storage: key and value memories, valid marks and access counts,
// one registered read port and one write port.
// ----------------------------------------------------------------------------
module lfu_store (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [lfu_pkg::IDX_W-1:0]  rd_addr,
	output lfu_pkg::st_rd_t                 rd,
	input  wire lfu_pkg::st_wr_t            wr
);
	import lfu_pkg::*;

	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];
	logic                  valid_q [ENTRIES];
	logic [COUNT_BITS-1:0] count_q [ENTRIES];

	// key and value memories, registered read
	always_ff @(posedge clk) begin
		if (wr.we && wr.key_en) begin
			key_mem[wr.idx] <= wr.key;
		end
		if (wr.we && wr.val_en) begin
			val_mem[wr.idx] <= wr.value;
		end
		rd.key   <= key_mem[rd_addr];
		rd.value <= val_mem[rd_addr];
		rd.valid <= valid_q[rd_addr];
		rd.count <= count_q[rd_addr];
	end

	// valid marks and counts, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				count_q[i] <= '0;
			end
		end else if (wr.we) begin
			valid_q[wr.idx] <= wr.valid;
			count_q[wr.idx] <= wr.count;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lfu_cmp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cmp_unit
// Shared compare unit: key equality and count ordering for one slot a cycle.
// ----------------------------------------------------------------------------
module lfu_cmp_unit (
	input  wire logic [lfu_pkg::KEY_BITS-1:0]   key_a,
	input  wire logic [lfu_pkg::KEY_BITS-1:0]   key_b,
	input  wire logic [lfu_pkg::COUNT_BITS-1:0] cnt_a,
	input  wire logic [lfu_pkg::COUNT_BITS-1:0] cnt_b,
	output logic                                key_eq,
	output logic                                cnt_le
);
	import lfu_pkg::*;

	// equality and less-or-equal
	assign key_eq = (key_a == key_b);
	assign cnt_le = (cnt_a <= cnt_b);

endmodule
`default_nettype wire

// ===== sv/lfu_cache_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Least-frequently-used cache table with get, update, insert and delete.
// ----------------------------------------------------------------------------
// One request is handled at a time. After a request is taken, the sequencer
// reads one slot per cycle through the slot storage and checks it with a
// single shared comparator, stopping at the first hit (or first free slot
// for insert) or after the last of n active slots, where n is entries_in_use
// clamped to 1..16; the write step then writes the slot on a hit and loads
// the result register. A result still waiting in the result register holds
// the write step until it is taken. The result register holds a finished
// result while the next request is already being accepted.
// ----------------------------------------------------------------------------
module lfu_cache_table_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration: entries_in_use
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lfu_pkg::CFG_W-1:0]       cfg_data,
	// request: tdata = key[63:0], value[127:64]; tuser = func[1:0]
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [lfu_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic [lfu_pkg::FUNC_W-1:0]      s_tuser,
	// result: tdata = read_value[63:0], slot[67:64], zero pad; tuser = hit
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [lfu_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic                                 m_tuser
);
	import lfu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      cfg_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      n_d;
	func_t                 op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  cmp_vld_s1;
	logic [CNT_W-1:0]      cmp_idx_s1;
	logic [IDX_W-1:0]      pick_q;
	logic [COUNT_BITS-1:0] min_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      tgt_q;
	logic [COUNT_BITS-1:0] tgt_cnt_q;
	logic [VALUE_BITS-1:0] rdval_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic                  m_tuser_q;

	st_rd_t                rd;
	st_wr_t                wr;
	logic                  key_eq;
	logic                  cnt_le;
	logic                  is_ins;
	logic                  found;
	logic                  last;
	logic [IDX_W-1:0]      cur_idx;
	logic [IDX_W-1:0]      pick_nxt;
	logic [COUNT_BITS-1:0] min_nxt;
	logic                  out_free;
	logic [SLOT_W-1:0]     res_slot;
	logic [VALUE_W-1:0]    res_val;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// active slot count, clamped to 1..ENTRIES
	always_comb begin
		if (cfg_q == '0) begin
			n_d = CNT_W'(1);
		end else if (int'(cfg_q) > ENTRIES) begin
			n_d = CNT_W'(ENTRIES);
		end else begin
			n_d = CNT_W'(cfg_q);
		end
	end

	// slot storage and shared comparator
	lfu_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd      (rd),
		.wr      (wr)
	);

	lfu_cmp_unit u_cmp (
		.key_a  (rd.key),
		.key_b  (key_q),
		.cnt_a  (rd.count),
		.cnt_b  (min_q),
		.key_eq (key_eq),
		.cnt_le (cnt_le)
	);

	// per-slot evaluation
	assign is_ins  = (op_q == FN_INSERT);
	assign cur_idx = cmp_idx_s1[IDX_W-1:0];
	assign found   = is_ins ? !rd.valid : (rd.valid && key_eq);
	assign last    = (cmp_idx_s1 == (n_q - CNT_W'(1)));

	// running minimum, last slot wins on ties
	always_comb begin
		if (cmp_idx_s1 == '0 || cnt_le) begin
			pick_nxt = cur_idx;
			min_nxt  = rd.count;
		end else begin
			pick_nxt = pick_q;
			min_nxt  = min_q;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// result fields, zero on a miss; the read value is zero except on a get
	assign res_val  = (hit_q && op_q == FN_GET) ? VALUE_W'(rdval_q) : '0;
	assign res_slot = hit_q ? SLOT_W'(tgt_q) : '0;

	// slot write at the end of a request
	always_comb begin
		wr        = '0;
		wr.idx    = tgt_q;
		wr.key    = key_q;
		wr.value  = val_q;
		wr.we     = (state_q == ST_WRITE) && out_free && hit_q;
		case (op_q)
			FN_GET: begin
				wr.valid = 1'b1;
				wr.count = (tgt_cnt_q == COUNT_MAX) ? tgt_cnt_q
					: tgt_cnt_q + COUNT_ONE;
			end
			FN_UPDATE: begin
				wr.valid  = 1'b1;
				wr.val_en = 1'b1;
				wr.count  = COUNT_ONE;
			end
			FN_INSERT: begin
				wr.valid  = 1'b1;
				wr.key_en = 1'b1;
				wr.val_en = 1'b1;
				wr.count  = COUNT_ONE;
			end
			default: begin
				wr.valid = 1'b0;
				wr.count = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= CNT_W'(1);
			op_q       <= FN_GET;
			key_q      <= '0;
			val_q      <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			pick_q     <= '0;
			min_q      <= '0;
			hit_q      <= 1'b0;
			tgt_q      <= '0;
			tgt_cnt_q  <= '0;
			rdval_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_WRITE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q       <= func_t'(s_tuser);
						key_q      <= s_tdata[KEY_BITS-1:0];
						val_q      <= s_tdata[KEY_W +: VALUE_BITS];
						n_q        <= n_d;
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// stop on the slot read last cycle, else issue the next read
					if (cmp_vld_s1 && (found || last)) begin
						cmp_vld_s1 <= 1'b0;
						hit_q      <= found || is_ins;
						tgt_q      <= found ? cur_idx : (is_ins ? pick_nxt : '0);
						tgt_cnt_q  <= rd.count;
						rdval_q    <= rd.value;
						state_q    <= ST_WRITE;
					end else if (rd_idx_q < n_q) begin
						rd_idx_q   <= rd_idx_q + CNT_W'(1);
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_idx_q;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					// running minimum over the slots read so far
					if (cmp_vld_s1) begin
						pick_q <= pick_nxt;
						min_q  <= min_nxt;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= hit_q;
						m_tdata_q  <= M_TDATA_W'({res_slot, res_val});
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a new result appears only out of the write step
	a_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_WRITE))
		else $error("result raised outside the write step");

	// a miss carries all-zero data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("miss result with nonzero data");

	// scan pointer never goes beyond the active slot count
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= n_q))
		else $error("scan pointer past active slots");

	// storage is written only in the write step
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == ST_WRITE && hit_q))
		else $error("slot write outside the write step");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lfu_cache_table_core. A shadow copy of the table
// predicts the reply to every request taken on the request stream, and each
// reply on the result stream is checked against it in order. Covers misses,
// duplicates, eviction ties, slot-count changes and count growth.
// ----------------------------------------------------------------------------

// one expected reply
typedef struct packed {
	logic        hit;
	logic [63:0] read_value;
	logic [3:0]  slot;
} lfu_reply_t;

// shadow copy of the table and the replies it still owes
class cache_mirror;
	logic [63:0] keys [16];
	logic [63:0] vals [16];
	bit          live [16];
	logic [15:0] uses [16];
	logic [4:0]  entries_in_use;
	lfu_reply_t  replies_due [$];
	int          errors;

	function new();
		entries_in_use = lfu_pkg::CFG_RESET;
		errors = 0;
		for (int i = 0; i < 16; i++) begin
			keys[i] = '0;
			vals[i] = '0;
			live[i] = 1'b0;
			uses[i] = '0;
		end
	endfunction

	function void set_entries(logic [4:0] n);
		entries_in_use = n;
	endfunction

	function int due();
		return replies_due.size();
	endfunction

	// zero acts as one, anything above the table size as the table size
	function int slots_taking_part();
		if (entries_in_use == 0)
			return 1;
		if (entries_in_use > lfu_pkg::ENTRIES)
			return lfu_pkg::ENTRIES;
		return int'(entries_in_use);
	endfunction

	// apply one taken request to the shadow table and queue its reply
	function void take_request(lfu_pkg::func_t fn, logic [63:0] k, logic [63:0] v);
		lfu_reply_t r;
		int n;
		int s;
		int pick;
		r = '0;
		n = slots_taking_part();
		s = -1;
		pick = 0;
		if (fn == lfu_pkg::FN_INSERT) begin
			// first free slot, else the last one holding the lowest count
			for (int i = 0; i < n; i++) begin
				if (s < 0 && !live[i])
					s = i;
				if (uses[i] <= uses[pick])
					pick = i;
			end
			if (s < 0)
				s = pick;
			keys[s] = k;
			vals[s] = v;
			live[s] = 1'b1;
			uses[s] = lfu_pkg::COUNT_ONE;
			r.hit = 1'b1;
			r.slot = 4'(s);
		end else begin
			for (int i = 0; i < n; i++) begin
				if (s < 0 && live[i] && keys[i] == k)
					s = i;
			end
			if (s >= 0) begin
				r.hit = 1'b1;
				r.slot = 4'(s);
				case (fn)
					lfu_pkg::FN_GET: begin
						r.read_value = vals[s];
						if (uses[s] != lfu_pkg::COUNT_MAX)
							uses[s] = uses[s] + 16'd1;
					end
					lfu_pkg::FN_UPDATE: begin
						vals[s] = v;
						uses[s] = lfu_pkg::COUNT_ONE;
					end
					default: begin
						live[s] = 1'b0;
						uses[s] = '0;
					end
				endcase
			end
		end
		replies_due.push_back(r);
	endfunction

	task report(string msg);
		if (errors < 100)
			$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	// compare one taken reply with the oldest one owed
	task check_reply(logic hit, logic [63:0] rd, logic [3:0] slot);
		lfu_reply_t e;
		if (replies_due.size() == 0) begin
			report($sformatf("reply with none owed (hit %0b slot %0d)", hit, slot));
		end else begin
			e = replies_due.pop_front();
			if (hit !== e.hit)
				report($sformatf("hit %0b, want %0b", hit, e.hit));
			if (rd !== e.read_value)
				report($sformatf("read_value %h, want %h", rd, e.read_value));
			if (slot !== e.slot)
				report($sformatf("slot %0d, want %0d", slot, e.slot));
		end
	endtask
endclass

module tb;
	import lfu_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 205;
	localparam int REPEAT_GETS = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0]    s_tuser = FN_GET;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	cache_mirror mirror = new();
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          stall_cycles = 0;
	logic [63:0] key_pool [8];
	logic [4:0]  phase_entries [8] = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd9, 5'd2, 5'd16};

	lfu_cache_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // key, value
		.s_tuser  (s_tuser),   // func
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // read_value, slot, zero pad
		.m_tuser  (m_tuser)    // hit
	);

	always #5 clk = ~clk;

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: check each taken reply, stall at random
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				mirror.check_reply(m_tuser, m_tdata[63:0], m_tdata[67:64]);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// present one request and hold it until taken; valid stays high after
	task automatic send_request(func_t fn, logic [63:0] k, logic [63:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {v, k};
		s_tuser <= fn;
		do @(posedge clk); while (!s_tready);
		mirror.take_request(fn, k, v);
	endtask

	// stop requests and wait for every owed reply
	task automatic settle_table();
		s_tvalid <= 1'b0;
		while (mirror.due() != 0)
			@(posedge clk);
	endtask

	task automatic write_entries(logic [4:0] n);
		settle_table();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror.set_entries(n);
	endtask

	// mostly pooled keys so lookups hit; now and then a fresh random key
	task automatic random_request();
		int r;
		func_t fn;
		logic [63:0] k;
		r = $urandom_range(99);
		if (r < 35)
			fn = FN_GET;
		else if (r < 50)
			fn = FN_UPDATE;
		else if (r < 78)
			fn = FN_INSERT;
		else
			fn = FN_DELETE;
		if ($urandom_range(9) == 0)
			k = {$urandom, $urandom};
		else
			k = key_pool[$urandom_range(7)];
		send_request(fn, k, {$urandom, $urandom});
	endtask

	initial begin
		logic [63:0] k_a, k_b, k_c, k_d;
		for (int i = 0; i < 8; i++)
			key_pool[i] = {$urandom, $urandom};
		k_a = {$urandom, $urandom};
		k_b = {$urandom, $urandom};
		k_c = {$urandom, $urandom};
		k_d = {$urandom, $urandom};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// misses on the empty table
		send_request(FN_GET, '0, '1);
		send_request(FN_UPDATE, '1, '1);
		send_request(FN_DELETE, '0, '0);
		// extremes, duplicate key, first-match behavior
		send_request(FN_INSERT, '0, '1);
		send_request(FN_INSERT, '1, '0);
		send_request(FN_INSERT, '0, 64'h5a5a_a5a5_0f0f_f0f0);
		send_request(FN_GET, '0, '0);
		send_request(FN_GET, '1, '1);
		send_request(FN_UPDATE, '0, 64'h0123_4567_89ab_cdef);
		send_request(FN_DELETE, '0, '0);
		send_request(FN_GET, '0, '0);
		send_request(FN_INSERT, k_a, 64'h1);
		// slots beyond the count drop out and rejoin unchanged
		write_entries(5'd1);
		send_request(FN_GET, '1, '0);
		send_request(FN_INSERT, k_b, 64'h2);
		write_entries(5'd0);
		send_request(FN_GET, k_b, '0);
		write_entries(5'd31);
		send_request(FN_GET, '1, '0);
		send_request(FN_GET, '0, '0);
		// full table: eviction, then a tie on the lowest count
		write_entries(5'd3);
		send_request(FN_INSERT, k_c, 64'h3);
		send_request(FN_UPDATE, '1, 64'h4);
		send_request(FN_INSERT, k_d, 64'h5);
		send_request(FN_GET, k_d, '0);

		// random phases across slot counts and idle patterns
		for (int p = 0; p < 8; p++) begin
			write_entries(phase_entries[p]);
			if (p < 3) begin
				send_idle_pct = 18;
				recv_idle_pct = 85;
			end else if (p < 6) begin
				send_idle_pct = 85;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (RANDOM_PER_PHASE) random_request();
		end

		// raise one count well above the rest, then show it is never evicted
		write_entries(5'd1);
		send_request(FN_INSERT, k_a, 64'h6);
		repeat (REPEAT_GETS) send_request(FN_GET, k_a, '0);
		write_entries(5'd2);
		send_request(FN_INSERT, k_b, 64'h7);
		send_request(FN_INSERT, k_c, 64'h8);
		send_request(FN_GET, k_a, '0);

		settle_table();
		repeat (24) @(posedge clk);
		if (mirror.due() != 0)
			mirror.report("replies still owed at end of run");
		if (mirror.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
